>>> rtl/assert_macros.svh
// Assertion helpers used by ext_pfx_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/ext_pfx_pkg.sv
package ext_pfx_pkg;

    // Field widths
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 13;
    localparam int DISP_W   = 8;
    localparam int IMM6_W   = 6;
    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 3;
    localparam int ERR_W    = 2;
    localparam int SCALED_W = IMM6_W + SIZE_W;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PREFIX = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IMM6   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SIGN6  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REG    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SP     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_THREE  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_PC     = 3'd6;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NO_PREFIX = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;

    // Input beat
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] prefix_imm;
        logic [DISP_W-1:0] short_imm;
        logic [DATA_W-1:0] base_value;
        logic [SIZE_W-1:0] access_size;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [ERR_W-1:0]  error;
    } t_out;

    // Extension slot state
    typedef struct packed {
        logic [SLOT_W-1:0] first_prefix;
        logic              first_valid;
        logic [SLOT_W-1:0] second_prefix;
        logic              second_valid;
    } t_slots;

endpackage

>>> rtl/ext_pfx_slots.sv
module ext_pfx_slots (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [ext_pfx_pkg::KIND_W-1:0] i_kind,
    input  logic [ext_pfx_pkg::SLOT_W-1:0] i_prefix_imm,
    output ext_pfx_pkg::t_slots           o_slots
);
    import ext_pfx_pkg::*;

    t_slots r_slots;
    t_slots n_slots;

    // Prefix fills the first free slot; a consuming kind empties both
    always_comb begin
        n_slots = r_slots;
        if (i_fire) begin
            unique case (i_kind)
                KIND_PREFIX: begin
                    if (!r_slots.first_valid) begin
                        n_slots.first_prefix = i_prefix_imm;
                        n_slots.first_valid  = 1'b1;
                    end else if (!r_slots.second_valid) begin
                        n_slots.second_prefix = i_prefix_imm;
                        n_slots.second_valid  = 1'b1;
                    end
                end
                KIND_IMM6, KIND_SIGN6, KIND_REG, KIND_SP, KIND_THREE, KIND_PC: begin
                    n_slots.first_valid  = 1'b0;
                    n_slots.second_valid = 1'b0;
                end
                default: begin
                    n_slots = r_slots;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
        end else begin
            r_slots <= n_slots;
        end
    end

    assign o_slots = r_slots;

endmodule

>>> rtl/ext_pfx_calc.sv
module ext_pfx_calc (
    input  ext_pfx_pkg::t_in    i_item,
    input  ext_pfx_pkg::t_slots i_slots,
    output ext_pfx_pkg::t_out   o_result
);
    import ext_pfx_pkg::*;

    logic                held2;
    logic                held1;
    logic [IMM6_W-1:0]   w_i6;
    logic [SLOT_W-1:0]   w_p1;
    logic [SLOT_W-1:0]   w_p2;
    logic [DISP_W-1:0]   w_s8;
    logic [DATA_W-1:0]   w_wide6;
    logic [DATA_W-1:0]   w_wide0;
    logic [DATA_W-1:0]   w_sign6;
    logic [DATA_W-1:0]   w_pc_off;
    logic [SCALED_W-1:0] w_scaled;
    logic [DATA_W-1:0]   w_addend;
    logic [DATA_W-1:0]   w_sum;

    assign held2 = i_slots.second_valid;
    assign held1 = i_slots.first_valid && !i_slots.second_valid;
    assign w_i6  = i_item.short_imm[IMM6_W-1:0];
    assign w_p1  = i_slots.first_prefix;
    assign w_p2  = i_slots.second_prefix;
    assign w_s8  = i_item.short_imm;

    // Own bits under the held prefixes, first prefix on top
    always_comb begin
        if (held2) begin
            w_wide6  = {w_p1, w_p2, w_i6};
            w_wide0  = {6'd0, w_p1, w_p2};
            w_sign6  = {w_p1, w_p2, w_i6};
            w_pc_off = {w_p1[SLOT_W-1:3], w_p2, w_s8, 1'b0};
        end else if (held1) begin
            w_wide6  = {13'd0, w_p1, w_i6};
            w_wide0  = {19'd0, w_p1};
            w_sign6  = {{13{w_p1[SLOT_W-1]}}, w_p1, w_i6};
            w_pc_off = {{10{w_p1[SLOT_W-1]}}, w_p1, w_s8, 1'b0};
        end else begin
            w_wide6  = {26'd0, w_i6};
            w_wide0  = '0;
            w_sign6  = {{26{w_i6[IMM6_W-1]}}, w_i6};
            w_pc_off = {{23{w_s8[DISP_W-1]}}, w_s8, 1'b0};
        end
    end

    // Unscaled-by-prefix stack offset: i6 times access size
    assign w_scaled = {{SIZE_W{1'b0}}, w_i6} * {{IMM6_W{1'b0}}, i_item.access_size};

    // Addend for the shared base adder
    always_comb begin
        unique case (i_item.kind)
            KIND_REG: w_addend = w_wide0;
            KIND_SP: begin
                if (held2 || held1) begin
                    w_addend = w_wide6;
                end else begin
                    w_addend = {{(DATA_W-SCALED_W){1'b0}}, w_scaled};
                end
            end
            KIND_PC:  w_addend = w_pc_off;
            default:  w_addend = '0;
        endcase
    end

    assign w_sum = i_item.base_value + w_addend;

    // Result select and error flags
    always_comb begin
        o_result.value = '0;
        o_result.error = ERR_OK;
        unique case (i_item.kind)
            KIND_PREFIX: begin
                if (i_slots.first_valid && i_slots.second_valid) begin
                    o_result.error = ERR_OVERFLOW;
                end
            end
            KIND_IMM6:  o_result.value = w_wide6;
            KIND_SIGN6: o_result.value = w_sign6;
            KIND_REG, KIND_SP, KIND_PC: o_result.value = w_sum;
            KIND_THREE: begin
                if (held2 || held1) begin
                    o_result.value = w_wide0;
                end else begin
                    o_result.error = ERR_NO_PREFIX;
                end
            end
            default: begin
                o_result.value = '0;
            end
        endcase
    end

endmodule

>>> rtl/ext_prefix_immediate_extender.sv
// Immediate extension unit: takes one beat per clock while o_stall is low, and
// returns exactly one result beat per input beat, in order (one input register,
// then the result register). The prefix slots are read and updated as a beat
// moves from the input register to the result register, so a prefix beat affects
// the very next beat behind it. With o_valid held by downstream stall, the input
// side keeps taking one more beat and then stalls.
module ext_prefix_immediate_extender (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ext_pfx_pkg::t_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output ext_pfx_pkg::t_out o_data
);
    import ext_pfx_pkg::*;

    logic   r_in_valid;
    t_in    r_in;
    logic   r_out_valid;
    t_out   r_out;
    logic   w_out_free;
    logic   w_advance;
    t_slots w_slots;
    t_out   w_result;

    // Pipeline flow control
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    ext_pfx_slots u_slots (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_advance),
        .i_kind       (r_in.kind),
        .i_prefix_imm (r_in.prefix_imm),
        .o_slots      (w_slots)
    );

    ext_pfx_calc u_calc (
        .i_item   (r_in),
        .i_slots  (w_slots),
        .o_result (w_result)
    );

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> rtl/ext_pfx_checker.sv
`include "assert_macros.svh"

module ext_pfx_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input ext_pfx_pkg::t_out o_data
);
    import ext_pfx_pkg::*;

    // Stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))

    // Only defined error codes leave the block
    `ASSERT_ALWAYS(a_err_code, i_clk, i_rst_n, !o_valid || o_data.error == ERR_OK || o_data.error == ERR_NO_PREFIX || o_data.error == ERR_OVERFLOW)

    // Dropped prefix reports a zero value
    `ASSERT_ALWAYS(a_ovf_zero, i_clk, i_rst_n, !(o_valid && o_data.error == ERR_OVERFLOW) || o_data.value == '0)

    // Three-operand use without prefix reports a zero value
    `ASSERT_ALWAYS(a_nopfx_zero, i_clk, i_rst_n, !(o_valid && o_data.error == ERR_NO_PREFIX) || o_data.value == '0)

endmodule

bind ext_prefix_immediate_extender ext_pfx_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

>>> sim/tb_ext_prefix_immediate_extender.sv
module tb_ext_prefix_immediate_extender;
    import ext_pfx_pkg::*;

    // Kind code the block leaves unused
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 475;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_data = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    ext_prefix_immediate_extender dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_in  pending_beats[$];
    t_out expected_results[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_asked = 0;
    int   mismatches = 0;

    // Prefix slots as the predictor sees them
    logic [SLOT_W-1:0] slot_p1 = '0;
    logic [SLOT_W-1:0] slot_p2 = '0;
    logic              slot_first_valid = 1'b0;
    logic              slot_second_valid = 1'b0;

    // Extended value and error for one beat; updates the prefix slots
    function automatic t_out predict_extension(input t_in b);
        t_out        r;
        logic [5:0]  i6;
        logic [31:0] wide6;
        logic [31:0] wide0;
        logic [31:0] disp;
        logic        consume;
        r = '0;
        consume = 1'b1;
        i6 = b.short_imm[IMM6_W-1:0];
        if (slot_second_valid) begin
            wide6 = {slot_p1, slot_p2, i6};
            wide0 = {6'b0, slot_p1, slot_p2};
        end else if (slot_first_valid) begin
            wide6 = {13'b0, slot_p1, i6};
            wide0 = {19'b0, slot_p1};
        end else begin
            wide6 = {26'b0, i6};
            wide0 = '0;
        end
        case (b.kind)
            KIND_PREFIX: begin
                consume = 1'b0;
                if (!slot_first_valid) begin
                    slot_p1 = b.prefix_imm;
                    slot_first_valid = 1'b1;
                end else if (!slot_second_valid) begin
                    slot_p2 = b.prefix_imm;
                    slot_second_valid = 1'b1;
                end else begin
                    r.error = ERR_OVERFLOW;
                end
            end
            KIND_IMM6: r.value = wide6;
            KIND_SIGN6: begin
                if (slot_second_valid)
                    r.value = wide6;
                else if (slot_first_valid)
                    r.value = {{13{slot_p1[12]}}, slot_p1, i6};
                else
                    r.value = {{26{i6[5]}}, i6};
            end
            KIND_REG: r.value = b.base_value + wide0;
            KIND_SP: begin
                // scaled by access size only with no prefix held
                if (slot_first_valid)
                    r.value = b.base_value + wide6;
                else
                    r.value = b.base_value + {26'b0, i6} * {29'b0, b.access_size};
            end
            KIND_THREE: begin
                if (slot_first_valid)
                    r.value = wide0;
                else
                    r.error = ERR_NO_PREFIX;
            end
            KIND_PC: begin
                if (slot_second_valid)
                    disp = {slot_p1[12], slot_p1[12:3], slot_p2, b.short_imm};
                else if (slot_first_valid)
                    disp = {{11{slot_p1[12]}}, slot_p1, b.short_imm};
                else
                    disp = {{24{b.short_imm[7]}}, b.short_imm};
                r.value = b.base_value + {disp[30:0], 1'b0};
            end
            default: consume = 1'b0;
        endcase
        if (consume) begin
            slot_first_valid = 1'b0;
            slot_second_valid = 1'b0;
        end
        return r;
    endfunction

    function automatic t_in make_beat(input logic [KIND_W-1:0] kind,
                                      input logic [SLOT_W-1:0] pimm,
                                      input logic [DISP_W-1:0] simm,
                                      input logic [DATA_W-1:0] base,
                                      input logic [SIZE_W-1:0] size);
        t_in b;
        b.kind = kind;
        b.prefix_imm = pimm;
        b.short_imm = simm;
        b.base_value = base;
        b.access_size = size;
        return b;
    endfunction

    // Random content; access size mostly legal, sometimes any code
    function automatic t_in random_beat(input logic [KIND_W-1:0] kind);
        logic [SIZE_W-1:0] size;
        int pick;
        pick = $urandom_range(3);
        if ($urandom_range(99) < 25)
            size = SIZE_W'($urandom_range(7));
        else
            size = (pick == 0) ? 3'd1 : (pick == 1) ? 3'd2 : 3'd4;
        return make_beat(kind, SLOT_W'($urandom), DISP_W'($urandom), $urandom, size);
    endfunction

    // Mostly prefix runs ending in a consuming beat, some noise beats
    task automatic queue_random_run(inout int count);
        int roll;
        int npfx;
        roll = $urandom_range(99);
        if (roll < 85) begin
            npfx = (roll < 8) ? 3 : $urandom_range(2);
            repeat (npfx) pending_beats.push_back(random_beat(KIND_PREFIX));
            pending_beats.push_back(random_beat(KIND_W'($urandom_range(KIND_PC, KIND_IMM6))));
            count += npfx + 1;
        end else begin
            pending_beats.push_back(random_beat(KIND_W'($urandom_range(7))));
            count += 1;
        end
    endtask

    // Wait until every beat has gone in and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || i_valid || expected_results.size() != 0);
    endtask

    // Driver: offers queued beats, predicts each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_results.push_back(predict_extension(i_data));
            if (!i_valid || !o_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_data <= pending_beats.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks result beats, drives the receiver stall
    always @(posedge i_clk) begin : monitor_proc
        t_out want;
        int   hold_left;
        int   hold_seen;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: value %h error %0d", o_data.value,
                       o_data.error);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_data.value !== want.value) begin
                    $error("value mismatch: expected %h, actual %h", want.value,
                           o_data.value);
                    mismatches++;
                end
                if (o_data.error !== want.error) begin
                    $error("error mismatch: expected %0d, actual %0d", want.error,
                           o_data.error);
                    mismatches++;
                end
            end
        end
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        int count;
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 59, 0, 21};
        recv_pct = '{0, 0, 59, 21};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats: extremes, every kind, overflow and no-prefix cases
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h1fff, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_IMM6, 13'h0000, 8'hff, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h1fff, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h1fff, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_SIGN6, 13'h0000, 8'h3f, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_SIGN6, 13'h1fff, 8'ha0, 32'hffffffff, 3'd4));
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h1000, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_REG, 13'h0000, 8'h00, 32'hffffffff, 3'd2));
        pending_beats.push_back(make_beat(KIND_THREE, 13'h1fff, 8'hff, 32'hffffffff, 3'd7));
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h0aaa, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h1555, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_THREE, 13'h0000, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h1fff, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h0001, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h1234, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_PC, 13'h0000, 8'h80, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_PC, 13'h0000, 8'h7f, 32'hffffffff, 3'd1));
        pending_beats.push_back(make_beat(KIND_SP, 13'h0000, 8'hff, 32'hfffffff0, 3'd0));
        pending_beats.push_back(make_beat(KIND_SP, 13'h0000, 8'hff, 32'hfffffff0, 3'd3));
        pending_beats.push_back(make_beat(KIND_SP, 13'h0000, 8'hff, 32'hfffffff0, 3'd7));
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h0fff, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_SP, 13'h0000, 8'hc1, 32'h80000000, 3'd4));
        pending_beats.push_back(make_beat(KIND_PREFIX, 13'h0155, 8'h00, 32'h0, 3'd1));
        pending_beats.push_back(make_beat(KIND_UNUSED, 13'h1fff, 8'hff, 32'hffffffff, 3'd7));
        pending_beats.push_back(make_beat(KIND_IMM6, 13'h0000, 8'h2a, 32'h0, 3'd1));
        wait_drained();

        // Random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            count = 0;
            while (count < PHASE_ITEMS) queue_random_run(count);
            // long receiver hold-off while beats keep coming
            if (ph == 0 || ph == 3) hold_asked++;
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_ext_prefix_immediate_extender passed");
        end else begin
            $display("tb_ext_prefix_immediate_extender failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("tb_ext_prefix_immediate_extender failed");
        $finish;
    end

endmodule
